@@ rtl/core/obdpid_pkg.sv @@
// Shared types and constants for the mode-01 PID reply decoder.
`timescale 1ns / 1ps

package obdpid_pkg;

  localparam int CHAR_W    = 8;
  localparam int PID_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int READING_W = 17;

  // requested_pid codes
  localparam logic [PID_W-1:0] PID_RPM     = 2'd0;
  localparam logic [PID_W-1:0] PID_SPEED   = 2'd1;
  localparam logic [PID_W-1:0] PID_COOLANT = 2'd2;
  localparam logic [PID_W-1:0] PID_MAF     = 2'd3;

  // characters with a role of their own
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_PROMPT = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;

  localparam logic signed [READING_W-1:0] COOLANT_OFFSET = 17'sd40;

  typedef enum logic [1:0] {
    STAGE_PREFIX = 2'd0,
    STAGE_BYTE_A = 2'd1,
    STAGE_BYTE_B = 2'd2,
    STAGE_DONE   = 2'd3
  } stage_t;

  // one decoded reading
  typedef struct packed {
    logic signed [READING_W-1:0] reading;
    logic                        prefix_matched;
  } result_t;

  // per-character control from the top level to the parser
  typedef struct packed {
    logic              step;
    logic [CHAR_W-1:0] ch;
    logic [PID_W-1:0]  pid;
  } parse_ctrl_t;

endpackage

@@ rtl/core/obdpid_if.sv @@
// Valid/ready channel interfaces for reply characters and decoded readings.
`timescale 1ns / 1ps

interface obdpid_in_if import obdpid_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;

  modport source(output valid, output ch, input ready);
  modport sink(input valid, input ch, output ready);
endinterface

interface obdpid_out_if import obdpid_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [READING_W-1:0] reading;
  logic                        prefix_matched;

  modport source(output valid, output reading, output prefix_matched, input ready);
  modport sink(input valid, input reading, input prefix_matched, output ready);
endinterface

@@ rtl/core/obdpid_parser.sv @@
// Reply parser: prefix match, hex byte capture and reading scaling.
`timescale 1ns / 1ps

module obdpid_parser import obdpid_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  parse_ctrl_t ctrl,
  output result_t     res
);

  stage_t              stage, stage_next;
  logic [1:0]          prefix_index, prefix_index_next;
  logic [BYTE_W-1:0]   byte_a, byte_a_next;
  logic [BYTE_W-1:0]   byte_b, byte_b_next;
  logic                digit_count, digit_count_next;
  logic                match_failed, match_failed_next;

  function automatic logic [CHAR_W-1:0] prefix_char(logic [PID_W-1:0] pid,
                                                    logic [1:0] idx);
    logic [CHAR_W-1:0] last;
    begin
      case (pid)
        PID_RPM:     last = 8'h43; // 'C'
        PID_SPEED:   last = 8'h44; // 'D'
        PID_COOLANT: last = 8'h35; // '5'
        default:     last = 8'h30; // '0'
      endcase
      case (idx)
        2'd0:    prefix_char = 8'h34;                              // '4'
        2'd1:    prefix_char = 8'h31;                              // '1'
        2'd2:    prefix_char = (pid == PID_MAF) ? 8'h31 : 8'h30;
        default: prefix_char = last;
      endcase
    end
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(logic [CHAR_W-1:0] c);
    begin
      if (c >= 8'h30 && c <= 8'h39)      hex_digit = {1'b1, c[3:0]};
      else if (c >= 8'h41 && c <= 8'h46) hex_digit = {1'b1, 4'(c[3:0] + 4'd9)};
      else if (c >= 8'h61 && c <= 8'h66) hex_digit = {1'b1, 4'(c[3:0] + 4'd9)};
      else                               hex_digit = 5'd0;
    end
  endfunction

  logic [4:0]        hex;
  logic              is_blank;
  logic              two_bytes;
  logic [15:0]       word;
  stage_t            closed_stage;

  assign hex       = hex_digit(ctrl.ch);
  assign is_blank  = (ctrl.ch == CH_SPACE) || (ctrl.ch == CH_TAB);
  assign two_bytes = (ctrl.pid == PID_RPM) || (ctrl.pid == PID_MAF);
  assign word      = {byte_a, byte_b};
  // stage after a byte closes
  assign closed_stage = (stage == STAGE_BYTE_A && two_bytes) ? STAGE_BYTE_B : STAGE_DONE;

  always_comb begin
    case (ctrl.pid)
      PID_RPM:     res.reading = READING_W'({2'b00, word[15:2]});
      PID_SPEED:   res.reading = READING_W'(byte_a);
      PID_COOLANT: res.reading = $signed(READING_W'(byte_a)) - COOLANT_OFFSET;
      default:     res.reading = READING_W'(word);
    endcase
    res.prefix_matched = (stage != STAGE_PREFIX) && !match_failed;
  end

  always_comb begin
    stage_next        = stage;
    prefix_index_next = prefix_index;
    byte_a_next       = byte_a;
    byte_b_next       = byte_b;
    digit_count_next  = digit_count;
    match_failed_next = match_failed;
    if (ctrl.step && ctrl.ch != CH_CR && ctrl.ch != CH_LF) begin
      if (ctrl.ch == CH_PROMPT) begin
        stage_next        = STAGE_PREFIX;
        prefix_index_next = '0;
        byte_a_next       = '0;
        byte_b_next       = '0;
        digit_count_next  = 1'b0;
        match_failed_next = 1'b0;
      end else begin
        case (stage)
          STAGE_PREFIX: begin
            if (ctrl.ch == prefix_char(ctrl.pid, prefix_index)) begin
              prefix_index_next = prefix_index + 2'd1;
              if (prefix_index == 2'd3) begin
                stage_next       = STAGE_BYTE_A;
                digit_count_next = 1'b0;
              end
            end else begin
              match_failed_next = 1'b1;
              stage_next        = STAGE_DONE;
            end
          end
          STAGE_BYTE_A, STAGE_BYTE_B: begin
            if (hex[4]) begin
              if (stage == STAGE_BYTE_A) byte_a_next = {byte_a[3:0], hex[3:0]};
              else                       byte_b_next = {byte_b[3:0], hex[3:0]};
              if (digit_count) begin
                digit_count_next = 1'b0;
                stage_next       = closed_stage;
              end else begin
                digit_count_next = 1'b1;
              end
            end else if (!digit_count) begin
              if (!is_blank) stage_next = STAGE_DONE;
            end else begin
              // one-digit byte ends; a blank may lead into the next byte, anything else ends the data
              digit_count_next = 1'b0;
              stage_next = (closed_stage == STAGE_BYTE_B && is_blank) ? STAGE_BYTE_B
                                                                      : STAGE_DONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage        <= STAGE_PREFIX;
      prefix_index <= '0;
      byte_a       <= '0;
      byte_b       <= '0;
      digit_count  <= 1'b0;
      match_failed <= 1'b0;
    end else begin
      stage        <= stage_next;
      prefix_index <= prefix_index_next;
      byte_a       <= byte_a_next;
      byte_b       <= byte_b_next;
      digit_count  <= digit_count_next;
      match_failed <= match_failed_next;
    end
  end

endmodule

@@ rtl/core/obd_pid_response_decoder_top.sv @@
// Top level of the mode-01 PID reply decoder: input register, parser, result register.
// Result path: an accepted '>' moves from the input register through the parser into the
//   result register, which raises result.valid.
// Throughput: one character per cycle; the only stall is a '>' meeting a full,
//   unread result register.
// Reset (rst, synchronous, active high): requested_pid = rpm, parser at prefix start,
//   both registers empty.
`timescale 1ns / 1ps

module obd_pid_response_decoder_top import obdpid_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [PID_W-1:0]  cfg_wdata,
  obdpid_in_if.sink         chars,
  obdpid_out_if.source      result
);

  // configuration register; the user must write it only while idle, the block does not enforce this
  logic [PID_W-1:0]  requested_pid;

  // input register: one character waiting to be parsed
  logic              in_valid;
  logic [CHAR_W-1:0] in_ch;

  // result register
  logic              out_valid;
  result_t           out_res;

  logic              is_prompt;
  logic              proc_fire;
  parse_ctrl_t       ctrl;
  result_t           parse_res;

  assign is_prompt = (in_ch == CH_PROMPT);
  // a character moves through the parser unless it is a prompt and the
  // result register is still held by the sink
  assign proc_fire = in_valid && (!is_prompt || !out_valid || result.ready);

  // input register refills in the same cycle it drains
  assign chars.ready = !in_valid || proc_fire;

  assign ctrl.step = proc_fire;
  assign ctrl.ch   = in_ch;
  assign ctrl.pid  = requested_pid;

  obdpid_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .res  (parse_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      requested_pid <= PID_RPM;
    end else if (cfg_we) begin
      requested_pid <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_ch <= chars.ch;
    end
  end

  // result register: load on a prompt, clear when the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire && is_prompt) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && is_prompt) begin
      out_res <= parse_res;
    end
  end

  assign result.valid          = out_valid;
  assign result.reading        = out_res.reading;
  assign result.prefix_matched = out_res.prefix_matched;

  // a held character is always a prompt blocked by an unread result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_valid && !proc_fire |-> is_prompt && out_valid && !result.ready)
    else $error("input register stalled without a blocked result");

  // a parsed prompt always produces a pending result
  a_prompt_result: assert property (@(posedge clk) disable iff (rst)
    proc_fire && is_prompt |=> out_valid)
    else $error("prompt parsed but no result pending");

  // a delivered result with no new prompt leaves the register empty
  a_result_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.ready && !(proc_fire && is_prompt) |=> !out_valid)
    else $error("result delivered twice");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the mode-01 PID reply decoder.
`timescale 1ns / 1ps

module testbench;
  import obdpid_pkg::*;

  localparam int RANDOM_CHARS = 1850;
  localparam int SETTLE       = 4;       // covers the input and result registers plus margin
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int CYCLE_LIMIT  = 2000000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [PID_W-1:0] cfg_wdata;

  obdpid_in_if  reply_chars ();
  obdpid_out_if readings ();

  obd_pid_response_decoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .chars     (reply_chars),
    .result    (readings)
  );

  // ---------------------------------------------------------------------------
  // Clock, reset, run bookkeeping
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  int      error_count = 0;
  int      cycle_count = 0;
  int      chars_sent  = 0;
  bit      quiet       = 1'b0;  // no random gaps on either side while set
  bit      hold_req    = 1'b0;  // asks the receiver for one long hold-off
  result_t expected_readings [$];

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet)  return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Decoder prediction: parser state, prefix count apart, mirrored at the block's widths
  // ---------------------------------------------------------------------------
  logic [PID_W-1:0]  pid_m;
  stage_t            stage_m;
  logic [2:0]        prefix_cnt;
  logic [BYTE_W-1:0] byte_a_m;
  logic [BYTE_W-1:0] byte_b_m;
  bit                half_m;     // one hex digit already taken into the current byte
  bit                mismatch_m;

  // Expected four-character prefix for a PID, first character in the top byte.
  function automatic logic [31:0] prefix_word(input logic [PID_W-1:0] pid);
    case (pid)
      PID_RPM:     return "410C";
      PID_SPEED:   return "410D";
      PID_COOLANT: return "4105";
      default:     return "4110";
    endcase
  endfunction

  function automatic int hex_value(input logic [CHAR_W-1:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  function automatic void clear_parser();
    stage_m    = STAGE_PREFIX;
    prefix_cnt = '0;
    byte_a_m   = '0;
    byte_b_m   = '0;
    half_m     = 1'b0;
    mismatch_m = 1'b0;
  endfunction

  function automatic void shift_digit(input logic [3:0] v);
    if (stage_m == STAGE_BYTE_A) byte_a_m = {byte_a_m[3:0], v};
    else                         byte_b_m = {byte_b_m[3:0], v};
  endfunction

  // Rpm and MAF carry two data bytes, speed and coolant one.
  function automatic void end_byte();
    half_m = 1'b0;
    if (stage_m == STAGE_BYTE_A && (pid_m == PID_RPM || pid_m == PID_MAF))
      stage_m = STAGE_BYTE_B;
    else
      stage_m = STAGE_DONE;
  endfunction

  // Data field character; a non-hex after one digit closes the byte and, where
  // another byte follows, is looked at again as the start of that one.
  function automatic void take_data_char(input logic [CHAR_W-1:0] c);
    int d;
    d = hex_value(c);
    for (int pass = 0; pass < 2; pass++) begin
      if (stage_m != STAGE_BYTE_A && stage_m != STAGE_BYTE_B) return;
      if (!half_m) begin
        if (c == CH_SPACE || c == CH_TAB) return;
        if (d < 0) begin
          stage_m = STAGE_DONE;
          return;
        end
        shift_digit(d[3:0]);
        half_m = 1'b1;
        return;
      end
      if (d >= 0) begin
        shift_digit(d[3:0]);
        end_byte();
        return;
      end
      end_byte();
    end
  endfunction

  // Advances the parser by one character; returns 1 when a reading is due.
  function automatic bit decode_char(input logic [CHAR_W-1:0] c, output result_t r);
    logic [15:0] word;
    logic [31:0] pfx;
    r = '0;
    if (c == CH_CR || c == CH_LF) return 1'b0;
    if (c == CH_PROMPT) begin
      word = {byte_a_m, byte_b_m};
      case (pid_m)
        PID_RPM:     r.reading = READING_W'(word >> 2);
        PID_SPEED:   r.reading = READING_W'(byte_a_m);
        PID_COOLANT: r.reading = $signed({9'd0, byte_a_m}) - COOLANT_OFFSET;
        default:     r.reading = READING_W'(word);
      endcase
      r.prefix_matched = (stage_m != STAGE_PREFIX) && !mismatch_m;
      clear_parser();
      return 1'b1;
    end
    if (stage_m == STAGE_PREFIX) begin
      pfx = prefix_word(pid_m);
      if (c == pfx[31 - 8 * prefix_cnt[1:0] -: 8]) begin
        prefix_cnt = prefix_cnt + 3'd1;
        if (prefix_cnt >= 3'd4) begin
          stage_m = STAGE_BYTE_A;
          half_m  = 1'b0;
        end
      end else begin
        mismatch_m = 1'b1;
        stage_m    = STAGE_DONE;
      end
    end else begin
      take_data_char(c);
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Reply character driver
  // ---------------------------------------------------------------------------
  // Offers one character and waits for the transaction. The prediction runs at
  // the accepting edge; a fixed expectation replaces the predicted reading when
  // pinned is set.
  task automatic put_char(input logic [CHAR_W-1:0] c, input bit pinned,
                          input result_t pinned_val);
    int      gap;
    result_t r;
    gap = idle_len();
    if (gap > 0) begin
      reply_chars.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    reply_chars.valid <= 1'b1;
    reply_chars.ch    <= c;
    @(posedge clk);
    while (!reply_chars.ready) @(posedge clk);
    if (decode_char(c, r)) expected_readings.push_back(pinned ? pinned_val : r);
    chars_sent++;
  endtask

  // Sender pause: stop offering until every reading is back and the pipe is empty.
  task automatic drain();
    reply_chars.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write while the block is idle; the parser state is kept, so a
  // write between two halves of a reply is legal.
  task automatic set_pid(input logic [PID_W-1:0] p);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pid_m = p;
  endtask

  // One random reply: mostly well-formed with random data, some with a bad or
  // foreign prefix, some cut short, some plain noise. CR/LF sprinkled in.
  task automatic send_reply();
    logic [CHAR_W-1:0] txt [$];
    logic [31:0]       pfx;
    int                kind;
    int                fields;
    int                digits;
    int                v;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      repeat ($urandom_range(0, 8)) txt.push_back(CHAR_W'($urandom_range(0, 255)));
    end else begin
      pfx = prefix_word(kind < 22 ? PID_W'($urandom_range(0, 3)) : pid_m);
      if (kind < 28) pfx[8 * $urandom_range(0, 3) +: 8] = CHAR_W'($urandom_range(0, 255));
      for (int i = 3; i >= 0; i--) txt.push_back(pfx[8 * i +: 8]);
      fields = (pid_m == PID_RPM || pid_m == PID_MAF) ? 2 : 1;
      if ($urandom_range(0, 9) == 0) fields++;
      for (int f = 0; f < fields; f++) begin
        repeat ($urandom_range(0, 2)) txt.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        v = $urandom_range(0, 9);
        digits = (v < 7) ? 2 : (v < 9) ? 1 : 0;
        for (int k = 0; k < digits; k++) begin
          v = $urandom_range(0, 15);
          if (v < 10)                    txt.push_back(CHAR_W'("0" + v));
          else if ($urandom_range(0, 1)) txt.push_back(CHAR_W'("a" + v - 10));
          else                           txt.push_back(CHAR_W'("A" + v - 10));
        end
        if (digits < 2 && $urandom_range(0, 1)) txt.push_back(CHAR_W'($urandom_range(0, 255)));
      end
      // cut short
      if (kind >= 28 && kind < 42) repeat ($urandom_range(1, txt.size())) void'(txt.pop_back());
      // trailing junk after the data
      if ($urandom_range(0, 4) == 0) txt.push_back(CHAR_W'($urandom_range(32, 126)));
    end
    repeat ($urandom_range(0, 2)) begin
      txt.insert($urandom_range(0, txt.size()), $urandom_range(0, 1) ? CH_CR : CH_LF);
    end
    txt.push_back(CH_PROMPT);
    foreach (txt[i]) put_char(txt[i], 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: PID, reply text, and a fixed expectation on the row's '>'
  // where the reading is obvious; other rows go through the predictor.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [PID_W-1:0] pid;
    string            text;
    bit               pinned;
    int               reading;
    bit               matched;
  } dir_row_t;

  localparam int DIR_ROWS = 11;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{PID_RPM,     ">",                 1'b1,     0, 1'b0},  // empty reply after reset
    '{PID_RPM,     "410CFFFF\r\n>",     1'b1, 16383, 1'b1},  // top rpm, CR/LF dropped
    '{PID_RPM,     "410c12>",           1'b1,     0, 1'b0},  // lower-case prefix letter
    '{PID_SPEED,   "410D 7f>",          1'b0,     0, 1'b0},  // lower-case data digit
    '{PID_SPEED,   "41>",               1'b1,     0, 1'b0},  // prefix cut short
    '{PID_COOLANT, "4105 00>",          1'b1,   -40, 1'b1},  // coolant floor
    '{PID_COOLANT, "4106>",             1'b1,   -40, 1'b0},  // wrong prefix
    '{PID_MAF,     "4110 A\tB>",        1'b0,     0, 1'b0},  // one-digit bytes, tab skip
    '{PID_MAF,     "4110FF ZZ>",        1'b1, 65280, 1'b1},  // second byte has no digit
    '{PID_RPM,     "41",                1'b0,     0, 1'b0},  // first half under rpm ...
    '{PID_SPEED,   "0D99\x00>",         1'b0,     0, 1'b0}   // ... rest under speed, NUL
  };

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    result_t     pin_val;
    int          phase;
    int          goal;
    logic [31:0] pfx_half;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    reply_chars.valid = 1'b0;
    reply_chars.ch    = '0;
    pid_m             = PID_RPM;
    clear_parser();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].pid != pid_m) set_pid(dir_rows[r].pid);
      pin_val.reading        = READING_W'(dir_rows[r].reading);
      pin_val.prefix_matched = dir_rows[r].matched;
      for (int i = 0; i < dir_rows[r].text.len(); i++) begin
        put_char(dir_rows[r].text[i], dir_rows[r].pinned, pin_val);
      end
    end

    // Random phases, each under one PID setting.
    phase = 0;
    goal  = chars_sent + RANDOM_CHARS;
    while (chars_sent < goal) begin
      if (phase == 2) begin
        // receiver stalls for a long stretch while replies keep coming, so the
        // result register fills and '>' backs up into the input
        quiet    = 1'b1;
        hold_req = 1'b1;
        while (hold_req) @(posedge clk);
      end else begin
        quiet = (phase % 5 == 3);
      end
      repeat (12) send_reply();
      quiet = 1'b0;
      // sometimes leave a prefix half done across the register write
      if ($urandom_range(0, 2) == 0) begin
        pfx_half = prefix_word(pid_m);
        for (int i = 0; i < $urandom_range(1, 3); i++) begin
          put_char(pfx_half[31 - 8 * i -: 8], 1'b0, '0);
        end
      end
      case (phase)
        0:       set_pid(PID_MAF);
        1:       set_pid(PID_RPM);
        2:       set_pid(PID_COOLANT);
        3:       set_pid(PID_SPEED);
        default: set_pid(PID_W'($urandom_range(0, 3)));
      endcase
      phase++;
    end

    // close any reply left open by the last phase, then wait it out
    put_char(CH_PROMPT, 1'b0, '0);
    drain();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Reading receiver: random ready, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    readings.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        readings.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet) begin
        readings.ready <= 1'b1;
        @(posedge clk);
      end else begin
        gap = idle_len();
        if (gap > 0) begin
          readings.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end else begin
          readings.ready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Reading checker: every output transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && readings.valid && readings.ready) begin
      if (expected_readings.size() == 0) begin
        $error("reading with none expected: reading %0d prefix_matched %0b",
               readings.reading, readings.prefix_matched);
        error_count++;
      end else begin
        exp_r = expected_readings.pop_front();
        if (readings.reading !== exp_r.reading) begin
          $error("reading: expected %0d, got %0d", exp_r.reading, readings.reading);
          error_count++;
        end
        if (readings.prefix_matched !== exp_r.prefix_matched) begin
          $error("prefix_matched: expected %0b, got %0b",
                 exp_r.prefix_matched, readings.prefix_matched);
          error_count++;
        end
      end
    end
  end

endmodule

@@ files.f @@
rtl/core/obdpid_pkg.sv
rtl/core/obdpid_if.sv
rtl/core/obdpid_parser.sv
rtl/core/obd_pid_response_decoder_top.sv
verif/testbench.sv
